FILE: sv/blg_pkg.sv
`timescale 1ns / 1ps
// Package for the battery level gauge.
// Holds the transfer payload types, command and register codes, and shared constants.
// No dependencies.
package blg_pkg;

   localparam int CMD_WIDTH      = 2;
   localparam int MV_WIDTH       = 12;
   localparam int PCT_WIDTH      = 7;
   localparam int INTERVAL_WIDTH = 16;
   localparam int COUNT_WIDTH    = 7;
   localparam int SUM_WIDTH      = 19;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [CMD_WIDTH-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_SAMPLE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_INIT   = 2'd2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FULL_MV      = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_EMPTY_MV     = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DEBOUNCE_PCT = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INTERVAL_MS  = 2'd3;

   localparam logic [MV_WIDTH-1:0]       FULL_MV_RESET      = 12'd2100;
   localparam logic [MV_WIDTH-1:0]       EMPTY_MV_RESET     = 12'd1650;
   localparam logic [PCT_WIDTH-1:0]      DEBOUNCE_PCT_RESET = 7'd2;
   localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_MS_RESET  = 16'd30000;

   localparam logic [PCT_WIDTH-1:0] PCT_FULL    = 7'd100;
   localparam logic [PCT_WIDTH-1:0] PCT_EMPTY   = 7'd0;
   localparam logic [PCT_WIDTH-1:0] LEVEL_SCALE = 7'd100;

   localparam int DIVIDEND_WIDTH    = SUM_WIDTH;
   localparam int DIVISOR_WIDTH     = MV_WIDTH;
   localparam int DIV_BITS_PER_STEP = 3;
   localparam int DIV_STEPS         = 7;
   localparam int DIV_WIDTH         = DIV_BITS_PER_STEP * DIV_STEPS;
   localparam int DIV_STEP_WIDTH    = 3;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] command;
      logic [MV_WIDTH-1:0]  sample_mv;
   } req_type;

   typedef struct packed {
      logic [PCT_WIDTH-1:0] shown_percent;
      logic                 shown_valid;
      logic                 level_changed;
      logic                 window_open;
      logic [MV_WIDTH-1:0]  average_mv;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic exec_item;
      logic avg_start;
      logic lvl_prep;
      logic lvl_start;
      logic lvl_finish;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] command;
      logic                 collecting;
      logic                 window_full;
      logic                 lvl_direct;
      logic                 div_done;
   } dp_status_type;

endpackage

FILE: sv/blg_divider.sv
`timescale 1ns / 1ps
// Restoring divider for the battery level gauge, three quotient bits per cycle.
// Depends on blg_pkg for widths and step counts.
module blg_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [blg_pkg::DIVIDEND_WIDTH-1:0] dividend,
   input  logic [blg_pkg::DIVISOR_WIDTH-1:0]  divisor,
   output logic                               done,
   output logic [blg_pkg::DIVIDEND_WIDTH-1:0] quotient
);

   logic [blg_pkg::DIV_WIDTH-1:0]      work_ff, work_in;
   logic [blg_pkg::DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [blg_pkg::DIV_STEP_WIDTH-1:0] step_ff, step_in;
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;

   logic [blg_pkg::DIVISOR_WIDTH-1:0]     rem_step;
   logic [blg_pkg::DIVISOR_WIDTH:0]       trial;
   logic [blg_pkg::DIV_BITS_PER_STEP-1:0] qbits;

   always_comb begin
      rem_step = rem_ff;
      qbits    = '0;
      for (int i = 0; i < blg_pkg::DIV_BITS_PER_STEP; i++) begin
         trial = {rem_step, work_ff[blg_pkg::DIV_WIDTH-1-i]};
         if (trial >= {1'b0, divisor}) begin
            rem_step = blg_pkg::DIVISOR_WIDTH'(trial - {1'b0, divisor});
            qbits[blg_pkg::DIV_BITS_PER_STEP-1-i] = 1'b1;
         end else begin
            rem_step = trial[blg_pkg::DIVISOR_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = {{(blg_pkg::DIV_WIDTH-blg_pkg::DIVIDEND_WIDTH){1'b0}}, dividend};
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[blg_pkg::DIV_WIDTH-blg_pkg::DIV_BITS_PER_STEP-1:0], qbits};
         rem_in  = rem_step;
         step_in = step_ff + 1'b1;
         if (step_ff == blg_pkg::DIV_STEP_WIDTH'(blg_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff[blg_pkg::DIVIDEND_WIDTH-1:0];

endmodule

FILE: sv/blg_datapath.sv
`timescale 1ns / 1ps
// Datapath of the battery level gauge: configuration, gauge state, level mapping and result.
// Depends on blg_pkg and blg_divider.
module blg_datapath #(
   parameter int SAMPLES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  blg_pkg::req_type                     req_data,
   input  logic                                 csr_write,
   input  logic [blg_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [blg_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   input  blg_pkg::ctrl_cmd_type                cmd,
   output blg_pkg::dp_status_type               status,
   output blg_pkg::rsp_type                     rsp_data
);

   // The average is a multiplication by a rounded-up reciprocal, which is exact for
   // every window sum of the register width and up to 64 samples.
   localparam int AVG_SHIFT     = 25;
   localparam int AVG_RECIP     = ((1 << AVG_SHIFT) + SAMPLES - 1) / SAMPLES;
   localparam int PRODUCT_WIDTH = blg_pkg::SUM_WIDTH + AVG_SHIFT + 1;

   logic [blg_pkg::MV_WIDTH-1:0]       full_mv_ff, empty_mv_ff;
   logic [blg_pkg::PCT_WIDTH-1:0]      debounce_ff;
   logic [blg_pkg::INTERVAL_WIDTH-1:0] interval_ff;

   logic [blg_pkg::CMD_WIDTH-1:0]      cmd_ff;
   logic [blg_pkg::MV_WIDTH-1:0]       mv_ff;

   logic [blg_pkg::INTERVAL_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic                               collecting_ff, collecting_in;
   logic [blg_pkg::COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [blg_pkg::SUM_WIDTH-1:0]      sum_ff, sum_in;
   logic [blg_pkg::PCT_WIDTH-1:0]      level_ff, level_in;
   logic                               level_valid_ff, level_valid_in;
   logic [blg_pkg::MV_WIDTH-1:0]       average_ff, average_in;
   logic                               changed_ff, changed_in;

   logic                               direct_ff;
   logic [blg_pkg::PCT_WIDTH-1:0]      direct_val_ff;
   logic [blg_pkg::SUM_WIDTH-1:0]      numerator_ff;
   blg_pkg::rsp_type                   rsp_ff;

   logic [blg_pkg::INTERVAL_WIDTH-1:0] elapsed_inc;
   logic [blg_pkg::MV_WIDTH-1:0]       src_mv, span_mv, diff_mv;
   logic [blg_pkg::PCT_WIDTH-1:0]      pct;
   logic [blg_pkg::PCT_WIDTH:0]        delta;
   logic [PRODUCT_WIDTH-1:0]           avg_product;
   logic                               div_start, div_done;
   logic [blg_pkg::DIVIDEND_WIDTH-1:0] div_dividend, div_quotient;
   logic [blg_pkg::DIVISOR_WIDTH-1:0]  div_divisor;

   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign src_mv      = (cmd_ff == blg_pkg::CMD_INIT) ? mv_ff : average_ff;
   assign span_mv     = full_mv_ff - empty_mv_ff;
   assign diff_mv     = src_mv - empty_mv_ff;
   assign pct         = direct_ff ? direct_val_ff : div_quotient[blg_pkg::PCT_WIDTH-1:0];
   assign avg_product = PRODUCT_WIDTH'(sum_ff) * PRODUCT_WIDTH'(AVG_RECIP);

   always_comb begin
      if (level_valid_ff) begin
         delta = (pct >= level_ff) ? {1'b0, pct - level_ff} : {1'b0, level_ff - pct};
      end else begin
         delta = {1'b0, pct} + 1'b1;
      end
   end

   assign div_start    = cmd.lvl_start;
   assign div_dividend = numerator_ff;
   assign div_divisor  = span_mv;

   blg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      elapsed_in     = elapsed_ff;
      collecting_in  = collecting_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      level_in       = level_ff;
      level_valid_in = level_valid_ff;
      average_in     = average_ff;
      changed_in     = changed_ff;
      if (cmd.load_req) begin
         changed_in = 1'b0;
      end
      if (cmd.exec_item) begin
         unique case (cmd_ff)
            blg_pkg::CMD_TICK: begin
               if (!collecting_ff && elapsed_inc >= interval_ff) begin
                  collecting_in = 1'b1;
                  elapsed_in    = '0;
                  count_in      = '0;
                  sum_in        = '0;
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
            blg_pkg::CMD_SAMPLE: begin
               if (collecting_ff) begin
                  sum_in   = sum_ff + blg_pkg::SUM_WIDTH'(mv_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            blg_pkg::CMD_INIT: begin
               elapsed_in    = '0;
               collecting_in = 1'b0;
               count_in      = '0;
               sum_in        = '0;
            end
            default: begin
            end
         endcase
      end
      if (cmd.avg_start) begin
         collecting_in = 1'b0;
         count_in      = '0;
         sum_in        = '0;
         average_in    = avg_product[AVG_SHIFT +: blg_pkg::MV_WIDTH];
      end
      if (cmd.lvl_finish) begin
         if (cmd_ff == blg_pkg::CMD_INIT || delta >= {1'b0, debounce_ff}) begin
            level_in       = pct;
            level_valid_in = 1'b1;
            changed_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_mv_ff     <= blg_pkg::FULL_MV_RESET;
         empty_mv_ff    <= blg_pkg::EMPTY_MV_RESET;
         debounce_ff    <= blg_pkg::DEBOUNCE_PCT_RESET;
         interval_ff    <= blg_pkg::INTERVAL_MS_RESET;
         elapsed_ff     <= '0;
         collecting_ff  <= 1'b0;
         count_ff       <= '0;
         sum_ff         <= '0;
         level_ff       <= '0;
         level_valid_ff <= 1'b0;
         average_ff     <= '0;
         changed_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               blg_pkg::CSR_FULL_MV:      full_mv_ff  <= csr_data[blg_pkg::MV_WIDTH-1:0];
               blg_pkg::CSR_EMPTY_MV:     empty_mv_ff <= csr_data[blg_pkg::MV_WIDTH-1:0];
               blg_pkg::CSR_DEBOUNCE_PCT: debounce_ff <= csr_data[blg_pkg::PCT_WIDTH-1:0];
               blg_pkg::CSR_INTERVAL_MS:  interval_ff <= csr_data;
               default: begin
               end
            endcase
         end
         elapsed_ff     <= elapsed_in;
         collecting_ff  <= collecting_in;
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         level_ff       <= level_in;
         level_valid_ff <= level_valid_in;
         average_ff     <= average_in;
         changed_ff     <= changed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff <= req_data.command;
         mv_ff  <= req_data.sample_mv;
      end
      if (cmd.lvl_prep) begin
         direct_ff     <= (src_mv >= full_mv_ff) || (src_mv <= empty_mv_ff);
         direct_val_ff <= (src_mv >= full_mv_ff) ? blg_pkg::PCT_FULL : blg_pkg::PCT_EMPTY;
         numerator_ff  <= {{(blg_pkg::SUM_WIDTH-blg_pkg::MV_WIDTH){1'b0}}, diff_mv}
                          * blg_pkg::SUM_WIDTH'(blg_pkg::LEVEL_SCALE);
      end
      if (cmd.out_load) begin
         rsp_ff.shown_percent <= level_valid_ff ? level_ff : '0;
         rsp_ff.shown_valid   <= level_valid_ff;
         rsp_ff.level_changed <= changed_ff;
         rsp_ff.window_open   <= collecting_ff;
         rsp_ff.average_mv    <= average_ff;
      end
   end

   assign status.command     = cmd_ff;
   assign status.collecting  = collecting_ff;
   assign status.window_full = ((count_ff + 1'b1) >= blg_pkg::COUNT_WIDTH'(SAMPLES));
   assign status.lvl_direct  = direct_ff;
   assign status.div_done    = div_done;
   assign rsp_data           = rsp_ff;

endmodule

FILE: sv/blg_controller.sv
`timescale 1ns / 1ps
// Controller state machine of the battery level gauge.
// Depends on blg_pkg for the command codes and the command and status structs.
module blg_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  blg_pkg::dp_status_type status,
   output blg_pkg::ctrl_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DECODE     = 4'd1;
   localparam logic [3:0] S_AVG_START  = 4'd2;
   localparam logic [3:0] S_LVL_PREP   = 4'd4;
   localparam logic [3:0] S_LVL_CHECK  = 4'd5;
   localparam logic [3:0] S_LVL_WAIT   = 4'd6;
   localparam logic [3:0] S_LVL_FINISH = 4'd7;
   localparam logic [3:0] S_DONE       = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.exec_item = 1'b1;
            if (status.command == blg_pkg::CMD_SAMPLE && status.collecting
                && status.window_full) begin
               state_in = S_AVG_START;
            end else if (status.command == blg_pkg::CMD_INIT) begin
               state_in = S_LVL_PREP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_AVG_START: begin
            cmd.avg_start = 1'b1;
            state_in      = S_LVL_PREP;
         end
         S_LVL_PREP: begin
            cmd.lvl_prep = 1'b1;
            state_in     = S_LVL_CHECK;
         end
         S_LVL_CHECK: begin
            if (status.lvl_direct) begin
               state_in = S_LVL_FINISH;
            end else begin
               cmd.lvl_start = 1'b1;
               state_in      = S_LVL_WAIT;
            end
         end
         S_LVL_WAIT: begin
            if (status.div_done) begin
               state_in = S_LVL_FINISH;
            end
         end
         S_LVL_FINISH: begin
            cmd.lvl_finish = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("Accepted request did not move to decode.");

   a_single_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("More than one datapath command issued in a cycle.");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("Result register loaded but no result offered.");

   a_average_then_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AVG_START) |=> (state_ff == S_LVL_PREP))
      else $error("Average did not lead to level mapping.");

endmodule

FILE: sv/battery_level_gauge.sv
`timescale 1ns / 1ps
// Battery level gauge: turns millisecond ticks and ADC samples into a debounced percent.
// The request channel carries a command (tick, sample or initial reading) and millivolts.
// Every accepted request yields exactly one transfer on the response channel, carrying
// the shown percent, its valid flag, a change flag, the window state and the last average.
// The csr channel writes full_mv, empty_mv, debounce_pct and interval_ms by index; it is
// always ready and should be used only while the gauge is idle.
// One request is processed at a time. A tick, a sample inside an unfinished window, an
// ignored sample or an unused command goes from decode straight to the result. An
// initial reading goes through level mapping, which skips the divider when the reading
// lies at or beyond a limit. A sample that closes the window first forms its average by
// a reciprocal multiplication and is then mapped on the same terms; the divider that
// maps the percent produces three quotient bits per cycle in seven steps.
// Synchronous reset restores the register defaults, clears all gauge state and drops
// any pending response. When the receiver stalls, the response is held in the output
// register; the gauge may take the next request meanwhile but holds its result until
// the previous one has been transferred.
// Depends on blg_pkg, blg_controller, blg_datapath and blg_divider.
module battery_level_gauge #(
   parameter int SAMPLES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  blg_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output blg_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [blg_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [blg_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   blg_pkg::ctrl_cmd_type  cmd;
   blg_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   blg_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   blg_datapath #(
      .SAMPLES (SAMPLES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
